// ----- rtl/integer_to_roman_numeral_macros.svh -----
// Assertion macros for the integer_to_roman_numeral block.
// Each use expects clk and arst_n in scope.
`ifndef INTEGER_TO_ROMAN_NUMERAL_MACROS_SVH
`define INTEGER_TO_ROMAN_NUMERAL_MACROS_SVH

`ifndef SYNTHESIS

`define I2R_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`define I2R_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define I2R_ASSERT_NOW(label, ante, cons, msg)

`define I2R_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

// ----- rtl/i2r_pkg.sv -----
`default_nettype none

package i2r_pkg;

	localparam int ValueW = 12;
	localparam int SymW = 8;
	localparam int PcW = 4;
	localparam int DigW = 4;
	localparam int PlaceW = 2;
	localparam int NumPlaces = 4;

	localparam logic [ValueW-1:0] MaxValue = 12'd3999;
	localparam int unsigned ThUnit = 1000;
	localparam int unsigned HuUnit = 100;
	localparam int unsigned TeUnit = 10;

	localparam logic [SymW-1:0] CharI = 8'h49;
	localparam logic [SymW-1:0] CharV = 8'h56;
	localparam logic [SymW-1:0] CharX = 8'h58;
	localparam logic [SymW-1:0] CharL = 8'h4c;
	localparam logic [SymW-1:0] CharC = 8'h43;
	localparam logic [SymW-1:0] CharD = 8'h44;
	localparam logic [SymW-1:0] CharM = 8'h4d;
	localparam logic [SymW-1:0] CharNul = 8'h00;

	// micro-ops
	localparam logic [2:0] OP_WAIT = 3'd0;
	localparam logic [2:0] OP_EXT_TH = 3'd1;
	localparam logic [2:0] OP_EXT_HU = 3'd2;
	localparam logic [2:0] OP_EXT_TU = 3'd3;
	localparam logic [2:0] OP_EMIT = 3'd4;
	localparam logic [2:0] OP_ERR = 3'd5;

	// letter select within a decimal place
	localparam logic [1:0] SEL_ONE = 2'd0;
	localparam logic [1:0] SEL_FIVE = 2'd1;
	localparam logic [1:0] SEL_TEN = 2'd2;

	// sequencing
	localparam logic [1:0] SEQ_LOAD = 2'd0;
	localparam logic [1:0] SEQ_NEXT = 2'd1;
	localparam logic [1:0] SEQ_DISPATCH = 2'd2;
	localparam logic [1:0] SEQ_HOME = 2'd3;

	// microprogram addresses
	localparam logic [PcW-1:0] PC_WAIT = 4'd0;
	localparam logic [PcW-1:0] PC_EXT_TH = 4'd1;
	localparam logic [PcW-1:0] PC_EXT_HU = 4'd2;
	localparam logic [PcW-1:0] PC_EXT_TU = 4'd3;
	localparam logic [PcW-1:0] PC_ONE3 = 4'd4;
	localparam logic [PcW-1:0] PC_ONE2 = 4'd5;
	localparam logic [PcW-1:0] PC_ONE1 = 4'd6;
	localparam logic [PcW-1:0] PC_FIVE3 = 4'd7;
	localparam logic [PcW-1:0] PC_FIVE2 = 4'd8;
	localparam logic [PcW-1:0] PC_FIVE1 = 4'd9;
	localparam logic [PcW-1:0] PC_FIVE0 = 4'd10;
	localparam logic [PcW-1:0] PC_NINE_A = 4'd11;
	localparam logic [PcW-1:0] PC_NINE_B = 4'd12;
	localparam logic [PcW-1:0] PC_FOUR_A = 4'd13;
	localparam logic [PcW-1:0] PC_FOUR_B = 4'd14;
	localparam logic [PcW-1:0] PC_ERR = 4'd15;

	typedef struct packed {
		logic [2:0] op;
		logic [1:0] sel;
		logic [1:0] seq;
		logic [PcW-1:0] target;
	} ctrl_t;

	typedef struct packed {
		logic [PcW-1:0] entry;
		logic more;
		logic bad;
	} stat_t;

	// compare at full width so large multiples of the unit do not wrap
	function automatic logic [DigW-1:0] digit_of(input logic [ValueW-1:0] r,
			input int unsigned unit);
		logic [DigW-1:0] d;
		d = '0;
		for (int k = 1; k < 10; k++) begin
			if (32'(r) >= 32'(k) * unit) begin
				d = DigW'(k);
			end
		end
		return d;
	endfunction

	function automatic logic [ValueW-1:0] part_of(input logic [DigW-1:0] d,
			input int unsigned unit);
		return ValueW'(32'(d) * unit);
	endfunction

	// routine entry for one decimal digit
	function automatic logic [PcW-1:0] entry_of(input logic [DigW-1:0] d);
		logic [PcW-1:0] pc;
		case (d)
			4'd1: pc = PC_ONE1;
			4'd2: pc = PC_ONE2;
			4'd3: pc = PC_ONE3;
			4'd4: pc = PC_FOUR_A;
			4'd5: pc = PC_FIVE0;
			4'd6: pc = PC_FIVE1;
			4'd7: pc = PC_FIVE2;
			4'd8: pc = PC_FIVE3;
			4'd9: pc = PC_NINE_A;
			default: pc = PC_WAIT;
		endcase
		return pc;
	endfunction

	function automatic logic [SymW-1:0] letter_of(input logic [PlaceW-1:0] place,
			input logic [1:0] sel);
		logic [SymW-1:0] one, five, ten, ch;
		case (place)
			2'd0: begin one = CharI; five = CharV; ten = CharX; end
			2'd1: begin one = CharX; five = CharL; ten = CharC; end
			2'd2: begin one = CharC; five = CharD; ten = CharM; end
			default: begin one = CharM; five = CharNul; ten = CharNul; end
		endcase
		case (sel)
			SEL_ONE: ch = one;
			SEL_FIVE: ch = five;
			SEL_TEN: ch = ten;
			default: ch = CharNul;
		endcase
		return ch;
	endfunction

endpackage

`default_nettype wire

// ----- rtl/i2r_ucode_rom.sv -----
`default_nettype none

module i2r_ucode_rom (
	input  logic [i2r_pkg::PcW-1:0] pc,
	output i2r_pkg::ctrl_t          ctrl
);

	always_comb begin
		ctrl = '{op: i2r_pkg::OP_WAIT, sel: i2r_pkg::SEL_ONE,
			seq: i2r_pkg::SEQ_LOAD, target: i2r_pkg::PC_WAIT};
		case (pc)
			i2r_pkg::PC_WAIT: begin
				ctrl.seq = i2r_pkg::SEQ_LOAD;
			end
			i2r_pkg::PC_EXT_TH: begin
				ctrl.op = i2r_pkg::OP_EXT_TH;
				ctrl.seq = i2r_pkg::SEQ_NEXT;
				ctrl.target = i2r_pkg::PC_EXT_HU;
			end
			i2r_pkg::PC_EXT_HU: begin
				ctrl.op = i2r_pkg::OP_EXT_HU;
				ctrl.seq = i2r_pkg::SEQ_NEXT;
				ctrl.target = i2r_pkg::PC_EXT_TU;
			end
			i2r_pkg::PC_EXT_TU: begin
				ctrl.op = i2r_pkg::OP_EXT_TU;
				ctrl.seq = i2r_pkg::SEQ_DISPATCH;
			end
			i2r_pkg::PC_ONE3: begin
				ctrl.op = i2r_pkg::OP_EMIT;
				ctrl.seq = i2r_pkg::SEQ_NEXT;
				ctrl.target = i2r_pkg::PC_ONE2;
			end
			i2r_pkg::PC_ONE2: begin
				ctrl.op = i2r_pkg::OP_EMIT;
				ctrl.seq = i2r_pkg::SEQ_NEXT;
				ctrl.target = i2r_pkg::PC_ONE1;
			end
			i2r_pkg::PC_ONE1: begin
				ctrl.op = i2r_pkg::OP_EMIT;
				ctrl.seq = i2r_pkg::SEQ_DISPATCH;
			end
			i2r_pkg::PC_FIVE3: begin
				ctrl.op = i2r_pkg::OP_EMIT;
				ctrl.sel = i2r_pkg::SEL_FIVE;
				ctrl.seq = i2r_pkg::SEQ_NEXT;
				ctrl.target = i2r_pkg::PC_ONE3;
			end
			i2r_pkg::PC_FIVE2: begin
				ctrl.op = i2r_pkg::OP_EMIT;
				ctrl.sel = i2r_pkg::SEL_FIVE;
				ctrl.seq = i2r_pkg::SEQ_NEXT;
				ctrl.target = i2r_pkg::PC_ONE2;
			end
			i2r_pkg::PC_FIVE1: begin
				ctrl.op = i2r_pkg::OP_EMIT;
				ctrl.sel = i2r_pkg::SEL_FIVE;
				ctrl.seq = i2r_pkg::SEQ_NEXT;
				ctrl.target = i2r_pkg::PC_ONE1;
			end
			i2r_pkg::PC_FIVE0: begin
				ctrl.op = i2r_pkg::OP_EMIT;
				ctrl.sel = i2r_pkg::SEL_FIVE;
				ctrl.seq = i2r_pkg::SEQ_DISPATCH;
			end
			i2r_pkg::PC_NINE_A: begin
				ctrl.op = i2r_pkg::OP_EMIT;
				ctrl.seq = i2r_pkg::SEQ_NEXT;
				ctrl.target = i2r_pkg::PC_NINE_B;
			end
			i2r_pkg::PC_NINE_B: begin
				ctrl.op = i2r_pkg::OP_EMIT;
				ctrl.sel = i2r_pkg::SEL_TEN;
				ctrl.seq = i2r_pkg::SEQ_DISPATCH;
			end
			i2r_pkg::PC_FOUR_A: begin
				ctrl.op = i2r_pkg::OP_EMIT;
				ctrl.seq = i2r_pkg::SEQ_NEXT;
				ctrl.target = i2r_pkg::PC_FOUR_B;
			end
			i2r_pkg::PC_FOUR_B: begin
				ctrl.op = i2r_pkg::OP_EMIT;
				ctrl.sel = i2r_pkg::SEL_FIVE;
				ctrl.seq = i2r_pkg::SEQ_DISPATCH;
			end
			i2r_pkg::PC_ERR: begin
				ctrl.op = i2r_pkg::OP_ERR;
				ctrl.seq = i2r_pkg::SEQ_HOME;
			end
			default: begin
				ctrl.seq = i2r_pkg::SEQ_HOME;
			end
		endcase
	end

endmodule

`default_nettype wire

// ----- rtl/i2r_datapath.sv -----
`default_nettype none

module i2r_datapath (
	input  logic                          clk,
	input  logic                          load,
	input  logic                          adv,
	input  logic [i2r_pkg::ValueW-1:0]    value,
	input  i2r_pkg::ctrl_t                ctrl,
	output i2r_pkg::stat_t                stat,
	output logic [i2r_pkg::SymW-1:0]      letter
);

	logic [i2r_pkg::ValueW-1:0] rem_q;
	logic [i2r_pkg::DigW-1:0]   dig_q [i2r_pkg::NumPlaces];
	logic [i2r_pkg::DigW-1:0]   dig_d [i2r_pkg::NumPlaces];
	logic [i2r_pkg::PlaceW-1:0] place_q;
	logic [i2r_pkg::PlaceW-1:0] fplace;
	logic [i2r_pkg::PlaceW:0]   top;
	logic                       found;
	logic [i2r_pkg::DigW-1:0]   d_th, d_hu, d_tu, units;

	assign d_th = i2r_pkg::digit_of(rem_q, i2r_pkg::ThUnit);
	assign d_hu = i2r_pkg::digit_of(rem_q, i2r_pkg::HuUnit);
	assign d_tu = i2r_pkg::digit_of(rem_q, i2r_pkg::TeUnit);
	assign units = i2r_pkg::DigW'(rem_q - i2r_pkg::part_of(d_tu, i2r_pkg::TeUnit));

	// digits as they stand after this step, for the next-digit search
	always_comb begin
		dig_d = dig_q;
		if (ctrl.op == i2r_pkg::OP_EXT_TU) begin
			dig_d[1] = d_tu;
			dig_d[0] = units;
		end
	end

	// highest nonzero digit below the current place, or over all places in the tens-and-units split step
	always_comb begin
		top = (ctrl.op == i2r_pkg::OP_EXT_TU) ? (i2r_pkg::PlaceW+1)'(i2r_pkg::NumPlaces)
			: {1'b0, place_q};
		found = 1'b0;
		fplace = '0;
		for (int p = 0; p < i2r_pkg::NumPlaces; p++) begin
			if ((i2r_pkg::PlaceW+1)'(p) < top && dig_d[p] != '0) begin
				found = 1'b1;
				fplace = i2r_pkg::PlaceW'(p);
			end
		end
	end

	assign stat.entry = i2r_pkg::entry_of(dig_d[fplace]);
	assign stat.more = found;
	assign stat.bad = (value == '0) || (value > i2r_pkg::MaxValue);
	assign letter = i2r_pkg::letter_of(place_q, ctrl.sel);

	always_ff @(posedge clk) begin
		if (load) begin
			rem_q <= value;
		end else if (adv) begin
			case (ctrl.op)
				i2r_pkg::OP_EXT_TH: begin
					dig_q[3] <= d_th;
					rem_q <= rem_q - i2r_pkg::part_of(d_th, i2r_pkg::ThUnit);
				end
				i2r_pkg::OP_EXT_HU: begin
					dig_q[2] <= d_hu;
					rem_q <= rem_q - i2r_pkg::part_of(d_hu, i2r_pkg::HuUnit);
				end
				i2r_pkg::OP_EXT_TU: begin
					dig_q[1] <= d_tu;
					dig_q[0] <= units;
				end
				default: ;
			endcase
		end
		if (adv && ctrl.seq == i2r_pkg::SEQ_DISPATCH && found) begin
			place_q <= fplace;
		end
	end

endmodule

`default_nettype wire

// ----- rtl/integer_to_roman_numeral.sv -----
// Integer to Roman numeral converter.
// Request channel: req_valid/req_stall with value (12-bit unsigned). Response
// channel: chr_valid/chr_stall with symbol (ASCII), last and error, one
// character per transfer, most significant letter first, last set on the
// final letter of a numeral.
// Values 1 to 3999 give 1 to 15 characters. Zero and values above 3999 give
// one transfer with symbol 0, last 1 and error 1.
// A microprogram sequences the work: after the request is taken, three steps
// split the value into thousands, hundreds, tens and units, then one step per
// character loads the output register. One request is in flight at a time:
// req_stall is high from the request edge until the last character has been
// loaded into the output register.
// A stalled receiver holds the output register and freezes the sequencer at
// its next output step; the splitting steps do not wait for it.
// Reset clears the sequencer to its wait step and drops chr_valid.
`default_nettype none
`include "integer_to_roman_numeral_macros.svh"

module integer_to_roman_numeral (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       req_valid,
	output logic                       req_stall,
	input  logic [i2r_pkg::ValueW-1:0] value,
	output logic                       chr_valid,
	input  logic                       chr_stall,
	output logic [i2r_pkg::SymW-1:0]   symbol,
	output logic                       last,
	output logic                       error
);

	logic [i2r_pkg::PcW-1:0]  pc_q, pc_d;
	i2r_pkg::ctrl_t           ctrl;
	i2r_pkg::stat_t           stat;
	logic [i2r_pkg::SymW-1:0] letter;
	logic                     accept, emit, adv, out_free, is_ext;
	logic                     chr_valid_q, last_q, error_q;
	logic [i2r_pkg::SymW-1:0] symbol_q;

	i2r_ucode_rom u_rom (
		.pc   (pc_q),
		.ctrl (ctrl)
	);

	i2r_datapath u_dp (
		.clk    (clk),
		.load   (accept),
		.adv    (adv),
		.value  (value),
		.ctrl   (ctrl),
		.stat   (stat),
		.letter (letter)
	);

	assign req_stall = (ctrl.seq != i2r_pkg::SEQ_LOAD);
	assign accept = req_valid && !req_stall;
	assign out_free = !chr_valid_q || !chr_stall;
	assign is_ext = ctrl.op inside {i2r_pkg::OP_EXT_TH, i2r_pkg::OP_EXT_HU,
		i2r_pkg::OP_EXT_TU};
	assign emit = (ctrl.op == i2r_pkg::OP_EMIT || ctrl.op == i2r_pkg::OP_ERR) && out_free;
	assign adv = is_ext || emit;

	always_comb begin
		case (ctrl.seq)
			i2r_pkg::SEQ_LOAD: pc_d = accept ? (stat.bad ? i2r_pkg::PC_ERR
				: i2r_pkg::PC_EXT_TH) : pc_q;
			i2r_pkg::SEQ_NEXT: pc_d = adv ? ctrl.target : pc_q;
			i2r_pkg::SEQ_DISPATCH: pc_d = adv ? (stat.more ? stat.entry
				: i2r_pkg::PC_WAIT) : pc_q;
			i2r_pkg::SEQ_HOME: pc_d = adv ? i2r_pkg::PC_WAIT : pc_q;
			default: pc_d = i2r_pkg::PC_WAIT;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= i2r_pkg::PC_WAIT;
			chr_valid_q <= 1'b0;
		end else begin
			pc_q <= pc_d;
			if (emit) begin
				chr_valid_q <= 1'b1;
			end else if (!chr_stall) begin
				chr_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			if (ctrl.op == i2r_pkg::OP_ERR) begin
				symbol_q <= i2r_pkg::CharNul;
				last_q <= 1'b1;
				error_q <= 1'b1;
			end else begin
				symbol_q <= letter;
				last_q <= (ctrl.seq == i2r_pkg::SEQ_DISPATCH) && !stat.more;
				error_q <= 1'b0;
			end
		end
	end

	assign chr_valid = chr_valid_q;
	assign symbol = symbol_q;
	assign last = last_q;
	assign error = error_q;

	`I2R_ASSERT_NEXT(a_bad_to_err, accept && stat.bad, pc_q == i2r_pkg::PC_ERR, "bad value not flagged")
	`I2R_ASSERT_NEXT(a_split_nonzero, pc_q == i2r_pkg::PC_EXT_TU, pc_q != i2r_pkg::PC_WAIT, "in-range value gave no digit")
	`I2R_ASSERT_NEXT(a_hold_on_stall, (ctrl.op == i2r_pkg::OP_EMIT || ctrl.op == i2r_pkg::OP_ERR) && chr_valid_q && chr_stall, $stable(pc_q), "sequencer moved while output blocked")
	`I2R_ASSERT_NOW(a_err_shape, chr_valid_q && error_q, last_q && symbol_q == i2r_pkg::CharNul, "malformed error response")

endmodule

`default_nettype wire
